// ===== rtl/sqvs_pkg.sv =====
// shared types, constants and sine lookup for the sprite quad vertex setup block
`timescale 1ns / 1ps
package sqvs_pkg;

  localparam int MAX_SLOTS  = 32;
  localparam int MAX_QUADS  = 8192;
  localparam int SLOT_W     = $clog2(MAX_SLOTS);
  localparam int SLOT_CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int VCNT_CAP   = MAX_QUADS * 4;
  localparam int VCNT_W     = $clog2(VCNT_CAP + 1);
  localparam int TEX_SLOT_W = 5;
  localparam int VIDX_W     = 15;

  localparam logic [15:0] SINE_LUT [0:64] = '{
    16'd0,     16'd804,   16'd1608,  16'd2411,  16'd3212,  16'd4011,  16'd4808,  16'd5602,
    16'd6393,  16'd7180,  16'd7962,  16'd8740,  16'd9512,  16'd10279, 16'd11039, 16'd11793,
    16'd12540, 16'd13279, 16'd14010, 16'd14733, 16'd15447, 16'd16151, 16'd16846, 16'd17531,
    16'd18205, 16'd18868, 16'd19520, 16'd20160, 16'd20788, 16'd21403, 16'd22006, 16'd22595,
    16'd23170, 16'd23732, 16'd24279, 16'd24812, 16'd25330, 16'd25833, 16'd26320, 16'd26791,
    16'd27246, 16'd27684, 16'd28106, 16'd28511, 16'd28899, 16'd29269, 16'd29622, 16'd29957,
    16'd30274, 16'd30572, 16'd30853, 16'd31114, 16'd31357, 16'd31581, 16'd31786, 16'd31972,
    16'd32138, 16'd32286, 16'd32413, 16'd32522, 16'd32610, 16'd32679, 16'd32729, 16'd32758,
    16'd32768
  };

  typedef struct packed {
    logic        new_scene;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] size_x;
    logic [31:0] size_y;
    logic [15:0] rotation_angle;
    logic [31:0] colour_rgba;
    logic        textured;
    logic [31:0] texture_id;
    logic [15:0] tiling;
  } sqvs_in_t;

  typedef struct packed {
    logic [31:0]           vert_x;
    logic [31:0]           vert_y;
    logic [31:0]           vert_z;
    logic [1:0]            corner;
    logic [31:0]           vert_colour;
    logic [TEX_SLOT_W-1:0] tex_slot;
    logic [15:0]           vert_tiling;
    logic [VIDX_W-1:0]     vertex_index;
    logic                  slot_full;
    logic                  batch_full;
    logic                  last;
  } sqvs_out_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [SLOT_W-1:0] slot;
  } sqvs_tok_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] idx;
    logic [31:0]       data;
  } sqvs_wr_t;

  // r in 0..16384, result q1.15
  function automatic logic signed [16:0] quarter_sine(input logic [14:0] r);
    logic [6:0]  i;
    logic [7:0]  f;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [23:0] d;
    begin
      i = r[14:8];
      f = r[7:0];
      if (i >= 7'd64) begin
        quarter_sine = 17'sd32768;
      end else begin
        lo = SINE_LUT[i];
        hi = SINE_LUT[i + 7'd1];
        d  = (hi - lo) * f;
        quarter_sine = $signed({1'b0, lo + 16'(d[23:8])});
      end
    end
  endfunction

  function automatic logic signed [16:0] sine16(input logic [15:0] a);
    logic [14:0]        r;
    logic signed [16:0] m;
    begin
      r = {1'b0, a[13:0]};
      m = a[14] ? quarter_sine(15'd16384 - r) : quarter_sine(r);
      sine16 = a[15] ? -m : m;
    end
  endfunction

endpackage

// ===== rtl/sqvs_slot_cell.sv =====
// one slot table entry with its stage of the texture search chain
`timescale 1ns / 1ps
module sqvs_slot_cell import sqvs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [SLOT_W-1:0]     idx,
  input  logic [31:0]           tid,
  input  logic [SLOT_CNT_W-1:0] count,
  input  sqvs_wr_t              wr,
  input  sqvs_tok_t             tok_in,
  output sqvs_tok_t             tok_out
);

  logic [31:0] entry;
  logic        hit;

  // slot 0 is the white slot and never holds a handle
  assign hit = (idx != '0) && (SLOT_CNT_W'(idx) < count) && (entry == tid);

  always_ff @(posedge clk) begin
    if (wr.en && wr.idx == idx) begin
      entry <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out.valid <= tok_in.valid;
      if (tok_in.valid && !tok_in.found && hit) begin
        tok_out.found <= 1'b1;
        tok_out.slot  <= idx;
      end else begin
        tok_out.found <= tok_in.found;
        tok_out.slot  <= tok_in.slot;
      end
    end
  end

endmodule

// ===== rtl/sprite_quad_vertex_setup_core.sv =====
// sprite quad vertex setup: slot search chain, rotation products and vertex output
// an accepted quad sends the search token through the slot cells, SEARCH registers the
//   rotation products and PROD registers the first vertex beat; quad_stall holds until
//   all four beats are out, and the texture search token walks one slot cell per cycle
// one vertex beat per cycle while vert_stall is low once emission starts, four beats per quad
// reset: slot count one, vertex count zero, no beat pending; table entries undefined
`timescale 1ns / 1ps
module sprite_quad_vertex_setup_core import sqvs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      quad_valid,
  output logic      quad_stall,
  input  sqvs_in_t  quad,
  output logic      vert_valid,
  input  logic      vert_stall,
  output sqvs_out_t vert
);

  typedef enum logic [1:0] {IDLE, SEARCH, PROD, EMIT} state_t;

  state_t                state;
  sqvs_in_t              q;
  logic signed [16:0]    sin_q;
  logic signed [16:0]    cos_q;
  logic                  start;
  logic [SLOT_CNT_W-1:0] slot_cnt;
  logic [VCNT_W-1:0]     vcnt;
  logic signed [48:0]    p_cx, p_sy, p_sx, p_cy;
  logic [SLOT_W-1:0]     slot;
  logic                  sfull;
  logic                  bfull;
  logic [VCNT_W-1:0]     base;
  logic [1:0]            k;

  sqvs_tok_t tok [0:MAX_SLOTS];
  sqvs_wr_t  wr;
  logic      done;
  logic      bfull_now;
  logic      bind_new;

  assign tok[0]     = '{valid: start, found: 1'b0, slot: '0};
  assign done       = tok[MAX_SLOTS].valid;
  assign bfull_now  = vcnt >= VCNT_W'(VCNT_CAP);
  assign bind_new   = !bfull_now && q.textured && !tok[MAX_SLOTS].found;
  assign wr.en      = done && bind_new && (slot_cnt < SLOT_CNT_W'(MAX_SLOTS));
  assign wr.idx     = SLOT_W'(slot_cnt);
  assign wr.data    = q.texture_id;
  assign quad_stall = state != IDLE;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_SLOTS; gi++) begin : g_cell
      sqvs_slot_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .idx     (SLOT_W'(gi)),
        .tid     (q.texture_id),
        .count   (slot_cnt),
        .wr      (wr),
        .tok_in  (tok[gi]),
        .tok_out (tok[gi+1])
      );
    end
  endgenerate

  // next corner to present
  logic [1:0]         kn;
  logic signed [50:0] vx, vy;
  logic signed [34:0] rx, ry, sx_sum, sy_sum;
  sqvs_out_t          vert_next;

  function automatic logic [31:0] sat32(input logic signed [34:0] v);
    begin
      if (v > 35'sh0_7FFF_FFFF) begin
        sat32 = 32'h7FFF_FFFF;
      end else if (v < -35'sh0_8000_0000) begin
        sat32 = 32'h8000_0000;
      end else begin
        sat32 = v[31:0];
      end
    end
  endfunction

  always_comb begin
    kn = (state == PROD) ? 2'd0 : k + 2'd1;
    // corners 0 and 3 take -size_x, corners 0 and 1 take -size_y
    vx = ((kn == 2'd1 || kn == 2'd2) ? 51'(p_cx) : -51'(p_cx))
       - ((kn[1]) ? 51'(p_sy) : -51'(p_sy));
    vy = ((kn == 2'd1 || kn == 2'd2) ? 51'(p_sx) : -51'(p_sx))
       + ((kn[1]) ? 51'(p_cy) : -51'(p_cy));
    rx = 35'((vx + 51'sd32768) >>> 16);
    ry = 35'((vy + 51'sd32768) >>> 16);
    sx_sum = 35'($signed(q.pos_x)) + rx;
    sy_sum = 35'($signed(q.pos_y)) + ry;
    vert_next.vert_x       = sat32(sx_sum);
    vert_next.vert_y       = sat32(sy_sum);
    vert_next.vert_z       = q.pos_z;
    vert_next.corner       = kn;
    vert_next.vert_colour  = q.colour_rgba;
    vert_next.tex_slot     = TEX_SLOT_W'(slot);
    vert_next.vert_tiling  = q.tiling;
    vert_next.vertex_index = bfull ? '0 : VIDX_W'(base + VCNT_W'(kn));
    vert_next.slot_full    = sfull;
    vert_next.batch_full   = bfull;
    vert_next.last         = kn == 2'd3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      start      <= 1'b0;
      slot_cnt   <= SLOT_CNT_W'(1);
      vcnt       <= '0;
      vert_valid <= 1'b0;
      k          <= '0;
    end else begin
      start <= 1'b0;
      case (state)
        IDLE: begin
          if (quad_valid) begin
            q     <= quad;
            sin_q <= sine16(quad.rotation_angle);
            cos_q <= sine16(quad.rotation_angle + 16'd16384);
            if (quad.new_scene) begin
              slot_cnt <= SLOT_CNT_W'(1);
              vcnt     <= '0;
            end
            start <= 1'b1;
            state <= SEARCH;
          end
        end
        SEARCH: begin
          if (done) begin
            p_cx  <= cos_q * $signed(q.size_x);
            p_sy  <= sin_q * $signed(q.size_y);
            p_sx  <= sin_q * $signed(q.size_x);
            p_cy  <= cos_q * $signed(q.size_y);
            bfull <= bfull_now;
            base  <= vcnt;
            sfull <= 1'b0;
            slot  <= '0;
            if (!bfull_now) begin
              vcnt <= vcnt + VCNT_W'(4);
              if (q.textured) begin
                if (tok[MAX_SLOTS].found) begin
                  slot <= tok[MAX_SLOTS].slot;
                end else if (slot_cnt < SLOT_CNT_W'(MAX_SLOTS)) begin
                  slot     <= SLOT_W'(slot_cnt);
                  slot_cnt <= slot_cnt + SLOT_CNT_W'(1);
                end else begin
                  sfull <= 1'b1;
                end
              end
            end
            state <= PROD;
          end
        end
        PROD: begin
          vert       <= vert_next;
          vert_valid <= 1'b1;
          k          <= '0;
          state      <= EMIT;
        end
        EMIT: begin
          if (!vert_stall) begin
            if (k == 2'd3) begin
              vert_valid <= 1'b0;
              state      <= IDLE;
            end else begin
              vert <= vert_next;
              k    <= kn;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_vcnt_cap: assert property (@(posedge clk) disable iff (rst)
    vcnt <= VCNT_W'(VCNT_CAP)) else $error("vertex count past capacity");
  a_slot_cnt: assert property (@(posedge clk) disable iff (rst)
    slot_cnt >= SLOT_CNT_W'(1) && slot_cnt <= SLOT_CNT_W'(MAX_SLOTS))
    else $error("slot count out of range");
  a_tok_state: assert property (@(posedge clk) disable iff (rst)
    done |-> state == SEARCH) else $error("search token outside search");
  a_beat_state: assert property (@(posedge clk) disable iff (rst)
    vert_valid |-> state == EMIT) else $error("beat outside emission");

endmodule

// ===== tb/tb_sprite_quad_vertex_setup_core.sv =====
// testbench for sprite_quad_vertex_setup_core: predicted vertex beats checked against the block
`timescale 1ns / 1ps
module tb_sprite_quad_vertex_setup_core;
  import sqvs_pkg::*;

  localparam int LIMIT_CYCLES = 5000000;
  localparam int TAIL_CYCLES  = MAX_SLOTS + 40;

  class vertex_board;
    logic [31:0] bound_ids [MAX_SLOTS];
    int unsigned bound_count;
    int unsigned vert_count;
    sqvs_out_t   expected_verts [$];
    int          errors;
    int          quads_seen;
    int          verts_checked;

    function new();
      bound_count = 1;
      vert_count  = 0;
      errors      = 0;
    endfunction

    // q1.15 sine over a quarter turn, linear interpolation between table points
    function int quarter_sin(int r);
      int i;
      int f;
      i = r >> 8;
      f = r & 255;
      if (i >= 64) return 32768;
      return int'(SINE_LUT[i]) + (((int'(SINE_LUT[i + 1]) - int'(SINE_LUT[i])) * f) >>> 8);
    endfunction

    function int angle_sin(logic [15:0] a);
      int m;
      m = a[14] ? quarter_sin(16384 - int'(a[13:0])) : quarter_sin(int'(a[13:0]));
      return a[15] ? -m : m;
    endfunction

    function logic [31:0] place(longint p, longint prod);
      longint v;
      v = p + ((prod + 32768) >>> 16);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
    endfunction

    function void note_quad(sqvs_in_t q);
      sqvs_out_t   v;
      int unsigned slot;
      int unsigned base;
      bit          sfull;
      bit          bfull;
      bit          hit;
      longint      sx, sy, dx, dy;
      int          sn, cs;
      quads_seen++;
      slot  = 0;
      sfull = 0;
      hit   = 0;
      if (q.new_scene) begin
        bound_count = 1;
        vert_count  = 0;
      end
      bfull = vert_count >= VCNT_CAP;
      if (!bfull && q.textured) begin
        for (int i = 1; i < bound_count; i++) begin
          if (!hit && bound_ids[i] == q.texture_id) begin
            slot = i;
            hit  = 1;
          end
        end
        if (!hit) begin
          if (bound_count < MAX_SLOTS) begin
            bound_ids[bound_count] = q.texture_id;
            slot = bound_count;
            bound_count++;
          end else begin
            sfull = 1;
          end
        end
      end
      base = vert_count;
      if (!bfull) vert_count += 4;
      sn = angle_sin(q.rotation_angle);
      cs = angle_sin(q.rotation_angle + 16'd16384);
      sx = longint'($signed(q.size_x));
      sy = longint'($signed(q.size_y));
      for (int k = 0; k < 4; k++) begin
        dx = (k == 1 || k == 2) ? sx : -sx;
        dy = (k >= 2) ? sy : -sy;
        v.vert_x       = place(longint'($signed(q.pos_x)), longint'(cs) * dx - longint'(sn) * dy);
        v.vert_y       = place(longint'($signed(q.pos_y)), longint'(sn) * dx + longint'(cs) * dy);
        v.vert_z       = q.pos_z;
        v.corner       = k[1:0];
        v.vert_colour  = q.colour_rgba;
        v.tex_slot     = slot[TEX_SLOT_W-1:0];
        v.vert_tiling  = q.tiling;
        v.vertex_index = bfull ? '0 : VIDX_W'(base + k);
        v.slot_full    = sfull;
        v.batch_full   = bfull;
        v.last         = (k == 3);
        expected_verts.push_back(v);
      end
    endfunction

    function void cmp(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $error("%s: expected %h, got %h", name, e, a);
        errors++;
      end
    endfunction

    function void check_vert(sqvs_out_t a);
      sqvs_out_t e;
      if (expected_verts.size() == 0) begin
        $error("unexpected vertex beat %p", a);
        errors++;
        return;
      end
      e = expected_verts.pop_front();
      verts_checked++;
      cmp("vert_x", e.vert_x, a.vert_x);
      cmp("vert_y", e.vert_y, a.vert_y);
      cmp("vert_z", e.vert_z, a.vert_z);
      cmp("corner", e.corner, a.corner);
      cmp("vert_colour", e.vert_colour, a.vert_colour);
      cmp("tex_slot", e.tex_slot, a.tex_slot);
      cmp("vert_tiling", e.vert_tiling, a.vert_tiling);
      cmp("vertex_index", e.vertex_index, a.vertex_index);
      cmp("slot_full", e.slot_full, a.slot_full);
      cmp("batch_full", e.batch_full, a.batch_full);
      cmp("last", e.last, a.last);
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      quad_valid;
  logic      quad_stall;
  sqvs_in_t  quad;
  logic      vert_valid;
  logic      vert_stall;
  sqvs_out_t vert;

  vertex_board board = new();
  bit          quiet;
  bit          hold_req;
  int          cycles;

  sprite_quad_vertex_setup_core u_top (
    .clk(clk), .rst(rst),
    .quad_valid(quad_valid), .quad_stall(quad_stall), .quad(quad),
    .vert_valid(vert_valid), .vert_stall(vert_stall), .vert(vert)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && vert_valid && !vert_stall) board.check_vert(vert);
  end

  function int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver stalls; a hold request keeps it stalled for a long stretch
  initial begin
    int n;
    vert_stall = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        vert_stall <= 1;
        for (int i = 0; i < 400; i++) @(posedge clk);
        hold_req = 0;
        vert_stall <= 0;
      end else begin
        n = gap_len();
        if (n > 0) begin
          vert_stall <= 1;
          repeat (n) @(posedge clk);
          vert_stall <= 0;
        end
      end
    end
  end

  task automatic send_quad(sqvs_in_t q);
    int n;
    quad       <= q;
    quad_valid <= 1;
    do @(posedge clk); while (quad_stall);
    board.note_quad(q);
    n = gap_len();
    if (n > 0) begin
      quad_valid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    quad_valid <= 0;
    while (board.expected_verts.size() != 0) @(posedge clk);
  endtask

  function logic [31:0] pick32();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      4, 5: return $urandom;
      default: return {{14{$urandom_range(0, 1) == 1}}, 18'($urandom)};
    endcase
  endfunction

  function sqvs_in_t rand_quad(int unsigned id_pool);
    sqvs_in_t q;
    q.new_scene      = ($urandom_range(0, 39) == 0);
    q.pos_x          = pick32();
    q.pos_y          = pick32();
    q.pos_z          = $urandom;
    q.size_x         = pick32();
    q.size_y         = pick32();
    q.rotation_angle = ($urandom_range(0, 7) == 0) ? 16'(16384 * $urandom_range(0, 3))
                                                   : 16'($urandom);
    q.colour_rgba    = $urandom;
    q.textured       = ($urandom_range(0, 4) != 0);
    q.texture_id     = ($urandom_range(0, 9) == 0) ? $urandom
                                                   : 32'hA5A5_0000 ^ $urandom_range(0, id_pool);
    q.tiling         = $urandom;
    return q;
  endfunction

  function sqvs_in_t plain_quad(bit scene, logic [31:0] p, logic [31:0] sz, logic [15:0] ang);
    sqvs_in_t q;
    q = '0;
    q.new_scene      = scene;
    q.pos_x          = p;
    q.pos_y          = ~p;
    q.pos_z          = p ^ 32'h5a5a_5a5a;
    q.size_x         = sz;
    q.size_y         = -sz;
    q.rotation_angle = ang;
    q.colour_rgba    = 32'hffff_ffff;
    q.tiling         = 16'h0100;
    return q;
  endfunction

  initial begin
    sqvs_in_t q;
    cycles     = 0;
    rst        = 1;
    quad_valid = 0;
    quad       = '0;
    quiet      = 0;
    hold_req   = 0;
    repeat (11) @(posedge clk);
    rst <= 0;

    // directed: extremes, saturation, cardinal and odd angles
    send_quad(plain_quad(1, 32'h0, 32'h0001_0000, 16'd0));
    send_quad(plain_quad(0, 32'h7fff_ffff, 32'h7fff_ffff, 16'd0));
    send_quad(plain_quad(0, 32'h8000_0000, 32'h8000_0000, 16'd16384));
    send_quad(plain_quad(0, 32'hffff_ffff, 32'h8000_0000, 16'd32768));
    send_quad(plain_quad(0, 32'h0012_3456, 32'h0040_0000, 16'd49152));
    send_quad(plain_quad(0, 32'h0, 32'h0010_0000, 16'd8192));
    send_quad(plain_quad(0, 32'h0, 32'h0010_0000, 16'hffff));
    send_quad(plain_quad(0, 32'h0, 32'h0010_0000, 16'h00ff));
    // same handle twice binds once; extreme handles
    q = plain_quad(0, 32'h0001_0000, 32'h0002_0000, 16'd100);
    q.textured = 1;
    q.texture_id = 32'h0;
    send_quad(q);
    q.texture_id = 32'hffff_ffff;
    send_quad(q);
    q.texture_id = 32'h0;
    send_quad(q);
    q.textured = 0;
    send_quad(q);
    // fill every slot, then overflow the table
    for (int i = 0; i < MAX_SLOTS + 2; i++) begin
      q = plain_quad(i == 0, 32'h0, 32'h0001_0000, 16'(i * 997));
      q.textured   = 1;
      q.texture_id = 32'h1000 + i;
      send_quad(q);
    end
    drain();

    // random, with a long receiver hold part way and a drained pause
    for (int i = 0; i < 274; i++) begin
      if (i == 60) hold_req = 1;
      if (i == 160) drain();
      if (i >= 200 && i < 240) quiet = 1;
      else quiet = 0;
      send_quad(rand_quad((i < 160) ? 20 : 48));
    end
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("quads sent: %0d, vertex beats checked: %0d", board.quads_seen,
             board.verts_checked);
    $display("covered slot binding and overflow, saturation, stalls and scene resets");
    if (board.errors == 0 && board.expected_verts.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
